// ===== hdl/proximity_vote_table_defines.svh =====
// ----------------------------------------------------------------------------
// proximity_vote_table_defines
// Assertion macros shared by the proximity vote table RTL.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_VOTE_TABLE_DEFINES_SVH
`define PROXIMITY_VOTE_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("proximity_vote_table assertion failed");

// next-cycle implication, disabled during reset
`define PVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("proximity_vote_table assertion failed");

`endif

// ===== hdl/pvt_pkg.sv =====
// ----------------------------------------------------------------------------
// pvt_pkg
// Types and constants for the proximity vote table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pvt_pkg;

  localparam int PVT_TABLE_ENTRIES = 32;

  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 15;
  localparam int VOTES_W  = 4;
  localparam int SLOT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = RADIUS_W;

  localparam logic [VOTES_W-1:0]  VOTE_MAX      = 4'd15;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 15'd102;
  localparam logic [VOTES_W-1:0]  CONFIRM_RESET = 4'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT = 2'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
  } pvt_in_t;

  typedef struct packed {
    logic                matched;
    logic                confirm_event;
    logic [SLOT_W-1:0]   slot;
    logic [VOTES_W-1:0]  slot_count;
  } pvt_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [VOTES_W-1:0]        votes;
    logic                      conf;
  } pvt_entry_t;

  typedef struct packed {
    logic               hit;
    logic               wr;
    logic               conf_evt;
    logic [VOTES_W-1:0] votes_new;
    logic               conf_new;
  } pvt_eval_t;

endpackage

`default_nettype wire

// ===== hdl/proximity_vote_table.sv =====
// ----------------------------------------------------------------------------
// proximity_vote_table
// Votes detected points into a table of remembered points.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carries one request: a point (x_pos, y_pos), signed Q8.8.
//   out_valid/out_stall returns one result per request: matched,
//   confirm_event, slot and slot_count.
//   cfg_we/cfg_index/cfg_data write match_radius (index 0) or confirm_count
//   (index 1); other indexes are ignored. The user must write them only while
//   the block is idle; the block itself does not enforce this.
// Sequence:
//   after accept, a registered table read, then one entry per cycle through the
//   shared compare unit, then finish and output load. in_stall is high until
//   the result is loaded, so a request is accepted only after the last is done.
// Reset: all entries empty at once (per-entry valid flags); radius 102, confirm 6.
// Stall:
//   A finished result waits in the output register while out_stall is high;
//   the next request is taken meanwhile and holds before its own result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "proximity_vote_table_defines.svh"

module proximity_vote_table
  import pvt_pkg::*;
#(
  parameter int TABLE_ENTRIES = PVT_TABLE_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pvt_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pvt_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW:0]   ENTRIES_C = (IW + 1)'(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [RADIUS_W-1:0]    radius_r, radius_nxt;
  logic [VOTES_W-1:0]     confirm_r, confirm_nxt;
  pvt_in_t                point_r, point_nxt;
  logic [IW:0]            rd_addr_r, rd_addr_nxt;
  logic                   chk_valid_r, chk_valid_nxt;
  logic [IW-1:0]          chk_idx_r, chk_idx_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic                   any_r, any_nxt;
  logic                   evt_r, evt_nxt;
  logic [IW-1:0]          first_r, first_nxt;
  logic [VOTES_W-1:0]     first_cnt_r, first_cnt_nxt;
  logic [IW-1:0]          best_idx_r, best_idx_nxt;
  logic [VOTES_W:0]       best_votes_r, best_votes_nxt;
  logic                   out_valid_r, out_valid_nxt;
  pvt_out_t               out_data_r, out_data_nxt;
  pvt_out_t               res_r, res_nxt;

  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  pvt_entry_t             mem_wdata;
  pvt_entry_t             mem_rdata;
  pvt_entry_t             cur_entry;
  pvt_eval_t              eval;

  pvt_entry_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr_r[IW-1:0]),
    .rdata (mem_rdata)
  );

  // empty entries read as zero votes, not confirmed
  always_comb begin
    cur_entry = mem_rdata;
    if (!valid_r[chk_idx_r]) begin
      cur_entry.votes = '0;
      cur_entry.conf  = 1'b0;
    end
  end

  pvt_match_unit u_match (
    .point   (point_r),
    .entry   (cur_entry),
    .radius  (radius_r),
    .confirm (confirm_r),
    .eval    (eval)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    radius_nxt     = radius_r;
    confirm_nxt    = confirm_r;
    point_nxt      = point_r;
    rd_addr_nxt    = rd_addr_r;
    chk_valid_nxt  = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    valid_nxt      = valid_r;
    any_nxt        = any_r;
    evt_nxt        = evt_r;
    first_nxt      = first_r;
    first_cnt_nxt  = first_cnt_r;
    best_idx_nxt   = best_idx_r;
    best_votes_nxt = best_votes_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    res_nxt        = res_r;
    mem_we         = 1'b0;
    mem_waddr      = chk_idx_r;
    mem_wdata      = '{x: cur_entry.x, y: cur_entry.y, votes: eval.votes_new,
                       conf: eval.conf_new};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH_RADIUS:  radius_nxt  = cfg_data;
        CFG_CONFIRM_COUNT: confirm_nxt = cfg_data[VOTES_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          point_nxt      = in_data;
          rd_addr_nxt    = '0;
          any_nxt        = 1'b0;
          evt_nxt        = 1'b0;
          first_nxt      = '0;
          first_cnt_nxt  = '0;
          best_idx_nxt   = '0;
          best_votes_nxt = {1'b1, {VOTES_W{1'b0}}};
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_addr_r < ENTRIES_C) begin
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = rd_addr_r[IW-1:0];
          rd_addr_nxt   = rd_addr_r + 1'b1;
        end
        if (chk_valid_r) begin
          if ({1'b0, cur_entry.votes} < best_votes_r) begin
            best_votes_nxt = {1'b0, cur_entry.votes};
            best_idx_nxt   = chk_idx_r;
          end
          if (eval.hit) begin
            any_nxt = 1'b1;
            if (!any_r) begin
              first_nxt     = chk_idx_r;
              first_cnt_nxt = eval.votes_new;
            end
          end
          if (eval.conf_evt) begin
            evt_nxt = 1'b1;
          end
          mem_we = eval.wr;
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!any_r) begin
          mem_we    = 1'b1;
          mem_waddr = best_idx_r;
          mem_wdata = '{x: point_r.x_pos, y: point_r.y_pos, votes: 4'd1, conf: 1'b0};
          valid_nxt[best_idx_r] = 1'b1;
          res_nxt = '{matched: 1'b0, confirm_event: 1'b0,
                      slot: SLOT_W'(best_idx_r), slot_count: 4'd1};
        end else begin
          res_nxt = '{matched: 1'b1, confirm_event: evt_r,
                      slot: SLOT_W'(first_r), slot_count: first_cnt_r};
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radius_r    <= RADIUS_RESET;
      confirm_r   <= CONFIRM_RESET;
      chk_valid_r <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radius_r    <= radius_nxt;
      confirm_r   <= confirm_nxt;
      chk_valid_r <= chk_valid_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    point_r      <= point_nxt;
    rd_addr_r    <= rd_addr_nxt;
    chk_idx_r    <= chk_idx_nxt;
    any_r        <= any_nxt;
    evt_r        <= evt_nxt;
    first_r      <= first_nxt;
    first_cnt_r  <= first_cnt_nxt;
    best_idx_r   <= best_idx_nxt;
    best_votes_r <= best_votes_nxt;
    out_data_r   <= out_data_nxt;
    res_r        <= res_nxt;
  end

  `PVT_ASSERT_NOW(a_out_rise_from_out, clk, rst_n,
                  $rose(out_valid_r), $past(state_r) == ST_OUT)
  `PVT_ASSERT_NOW(a_event_needs_match, clk, rst_n,
                  out_valid_r && out_data_r.confirm_event, out_data_r.matched)
  `PVT_ASSERT_NOW(a_replace_count_one, clk, rst_n,
                  out_valid_r && !out_data_r.matched, out_data_r.slot_count == 4'd1)
  `PVT_ASSERT_NOW(a_scan_write_checked, clk, rst_n,
                  mem_we && (state_r == ST_SCAN), chk_valid_r && valid_r[chk_idx_r])
  `PVT_ASSERT_NEXT(a_replace_sets_valid, clk, rst_n,
                   (state_r == ST_FINISH) && !any_r, valid_r[$past(best_idx_r)])

endmodule

`default_nettype wire

// ===== hdl/pvt_entry_mem.sv =====
// ----------------------------------------------------------------------------
// pvt_entry_mem
// Entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvt_entry_mem
  import pvt_pkg::*;
#(
  parameter int DEPTH = PVT_TABLE_ENTRIES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire pvt_entry_t    wdata,
  input  wire logic [AW-1:0] raddr,
  output pvt_entry_t         rdata
);

  pvt_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/pvt_match_unit.sv =====
// ----------------------------------------------------------------------------
// pvt_match_unit
// Shared window compare and vote update, applied to one entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvt_match_unit
  import pvt_pkg::*;
(
  input  wire pvt_in_t              point,
  input  wire pvt_entry_t           entry,
  input  wire logic [RADIUS_W-1:0]  radius,
  input  wire logic [VOTES_W-1:0]   confirm,
  output pvt_eval_t                 eval
);

  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic signed [COORD_W:0] rr;
  logic                    near_x;
  logic                    near_y;
  logic                    occupied;

  always_comb begin
    dx = {point.x_pos[COORD_W-1], point.x_pos} - {entry.x[COORD_W-1], entry.x};
    dy = {point.y_pos[COORD_W-1], point.y_pos} - {entry.y[COORD_W-1], entry.y};
    rr = {2'b00, radius};
    near_x = (dx > -rr) && (dx < rr);
    near_y = (dy > -rr) && (dy < rr);
    occupied = (entry.votes != '0);

    eval.hit       = occupied && near_x && near_y;
    eval.wr        = 1'b0;
    eval.conf_evt  = 1'b0;
    eval.votes_new = entry.votes;
    eval.conf_new  = entry.conf;
    if (eval.hit && !entry.conf) begin
      eval.wr       = 1'b1;
      eval.conf_evt = (entry.votes >= confirm);
      eval.conf_new = eval.conf_evt;
      if (entry.votes < VOTE_MAX) begin
        eval.votes_new = entry.votes + 4'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/proximity_vote_table_check.sv =====
// ----------------------------------------------------------------------------
// proximity_vote_table_check
// Watches the request, result and register ports of the proximity vote table,
// keeps its own copy of the vote table and registers, predicts the result of
// every accepted request and compares each accepted result with the oldest
// prediction. Mismatches and unexpected results add to fail_count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module proximity_vote_table_check
  import pvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  pvt_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  pvt_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    votes_awaited
);

  pvt_entry_t             vote_table [PVT_TABLE_ENTRIES];
  logic [RADIUS_W-1:0]    radius_now;
  logic [VOTES_W-1:0]     confirm_now;
  pvt_out_t               awaited_votes [$];

  function automatic pvt_out_t vote_point(pvt_in_t pt);
    int px, py, rad, dx, dy, first, best;
    logic hit, evt;
    pvt_out_t res;
    px = $signed(pt.x_pos);
    py = $signed(pt.y_pos);
    rad = int'(radius_now);
    hit = 1'b0;
    evt = 1'b0;
    first = 0;
    for (int i = 0; i < PVT_TABLE_ENTRIES; i++) begin
      if (vote_table[i].votes != '0) begin
        dx = px - $signed(vote_table[i].x);
        dy = py - $signed(vote_table[i].y);
        if (dx > -rad && dx < rad && dy > -rad && dy < rad) begin
          if (!hit) first = i;
          hit = 1'b1;
          if (!vote_table[i].conf) begin
            if (vote_table[i].votes >= confirm_now) begin
              vote_table[i].conf = 1'b1;
              evt = 1'b1;
            end
            if (vote_table[i].votes != VOTE_MAX)
              vote_table[i].votes = vote_table[i].votes + 1'b1;
          end
        end
      end
    end
    if (!hit) begin
      best = 0;
      for (int i = 1; i < PVT_TABLE_ENTRIES; i++)
        if (vote_table[i].votes < vote_table[best].votes) best = i;
      vote_table[best] = '{x: pt.x_pos, y: pt.y_pos, votes: 4'd1, conf: 1'b0};
      first = best;
    end
    res.matched       = hit;
    res.confirm_event = evt;
    res.slot          = first[SLOT_W-1:0];
    res.slot_count    = vote_table[first].votes;
    return res;
  endfunction

  always @(posedge clk) begin
    pvt_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < PVT_TABLE_ENTRIES; i++) vote_table[i] = '0;
      radius_now  = RADIUS_RESET;
      confirm_now = CONFIRM_RESET;
      awaited_votes.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_votes.size() == 0) begin
          $display("%0t: unexpected result matched=%0d event=%0d slot=%0d count=%0d",
                   $time, out_data.matched, out_data.confirm_event,
                   out_data.slot, out_data.slot_count);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_votes.pop_front();
          if (out_data !== want) begin
            $display("%0t: result mismatch expected matched=%0d event=%0d slot=%0d count=%0d",
                     $time, want.matched, want.confirm_event, want.slot, want.slot_count);
            $display("%0t:                   actual matched=%0d event=%0d slot=%0d count=%0d",
                     $time, out_data.matched, out_data.confirm_event,
                     out_data.slot, out_data.slot_count);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_votes.push_back(vote_point(in_data));
      if (cfg_we) begin
        case (cfg_index)
          CFG_MATCH_RADIUS:  radius_now  = cfg_data[RADIUS_W-1:0];
          CFG_CONFIRM_COUNT: confirm_now = cfg_data[VOTES_W-1:0];
          default: ;
        endcase
      end
    end
    votes_awaited <= awaited_votes.size();
  end

endmodule

// ===== tb/sv/proximity_vote_table_test.sv =====
// ----------------------------------------------------------------------------
// proximity_vote_table_test
// Top of the proximity vote table testbench. Drives a directed set of points
// (coordinate extremes, radius boundaries, repeated votes up to confirmation,
// several matches, ignored register indexes, zero and full radius, zero and
// full confirm count), then random phases under changing register settings
// where most points cluster around a few targets. Requests come in bursts,
// results are stalled on a separate pattern; the checker does the comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module proximity_vote_table_test;
  import pvt_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 40;
  localparam int RANDOM_ITEMS = 450;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  pvt_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pvt_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    votes_awaited;

  int                    cycle_count = 0;
  int                    burst_left = 0;
  int                    stall_mode = 0;
  int                    stall_left = 50;
  int                    radius_sel;
  logic [15:0]           centers [8];
  int                    n_centers;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  proximity_vote_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  proximity_vote_table_check u_vote_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .votes_awaited (votes_awaited)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL proximity_vote_table");
      $finish;
    end
  end

  // result side back-pressure under a stall mode that is picked anew at random
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[2];
    endcase
  end

  function automatic int next_gap();
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 15);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(20, 45);
        default: gap = $urandom_range(1, 6);
      endcase
    end
    burst_left = burst_left - 1;
    return gap;
  endfunction

  task automatic offer_point(input logic [15:0] xv, input logic [15:0] yv);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{x_pos: xv, y_pos: yv};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (votes_awaited == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic offer_random_point(input int radius);
    int j, k;
    logic [15:0] cx, cy;
    if (n_centers > 0 && $urandom_range(0, 3) != 0) begin
      j = (radius > 1) ? radius - 1 : 0;
      if (j > 600) j = 600;
      k = $urandom_range(0, n_centers - 1);
      cx = centers[k] + 16'($urandom_range(0, 2 * j)) - 16'(j);
      k = $urandom_range(0, n_centers - 1) % 2 == 0 ? k : k;
      cy = centers[(k + 1) % 8] + 16'($urandom_range(0, 2 * j)) - 16'(j);
      offer_point(cx, cy);
    end else begin
      offer_point(16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int sent, phase_len, radius, conf;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MATCH_RADIUS;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: extremes, voting up to confirmation, radius boundary
    offer_point(16'h8000, 16'h8000);
    offer_point(16'h7FFF, 16'h7FFF);
    offer_point(16'h0000, 16'h0000);
    offer_point(16'h8000, 16'h7FFF);
    offer_point(16'h7FFF, 16'h8000);
    repeat (7) offer_point(16'sd50, -16'sd50);
    offer_point(16'sd32665, 16'sd32767);
    offer_point(16'sd32666, 16'sd32666);

    // writes to spare indexes must leave the registers alone
    settle();
    write_reg(CFG_SPARE_2, 15'd0);
    write_reg(CFG_SPARE_3, 15'h7FFF);
    offer_point(16'sd50, -16'sd50);

    settle();
    write_reg(CFG_MATCH_RADIUS, 15'd0);
    offer_point(16'h0000, 16'h0000);
    offer_point(16'h0000, 16'h0000);

    settle();
    write_reg(CFG_MATCH_RADIUS, 15'h7FFF);
    write_reg(CFG_CONFIRM_COUNT, 15'd0);
    offer_point(16'h0000, 16'h0000);
    offer_point(16'h8000, 16'h8000);

    settle();
    write_reg(CFG_CONFIRM_COUNT, 15'd15);
    offer_point(16'sd100, 16'sd100);
    offer_point(16'sd100, 16'sd100);

    // random phases, each under its own register setting
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      radius_sel = $urandom_range(0, 7);
      case (radius_sel)
        0:       radius = 0;
        1:       radius = 1;
        2:       radius = 32767;
        3, 4:    radius = $urandom_range(2, 400);
        5:       radius = $urandom_range(400, 4000);
        6:       radius = $urandom_range(0, 32767);
        default: radius = 102;
      endcase
      case ($urandom_range(0, 5))
        0:       conf = 0;
        1:       conf = 15;
        2:       conf = 1;
        3:       conf = 14;
        default: conf = $urandom_range(0, 15);
      endcase
      write_reg(CFG_MATCH_RADIUS, 15'(radius));
      write_reg(CFG_CONFIRM_COUNT, (15'($urandom) & 15'h7FF0) | 15'(conf));
      n_centers = $urandom_range(1, 8);
      for (int i = 0; i < 8; i++) centers[i] = 16'($urandom);
      phase_len = $urandom_range(30, 70);
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        offer_random_point(radius);
        sent++;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && votes_awaited == 0) begin
      $display("PASS proximity_vote_table");
    end else begin
      $display("FAIL proximity_vote_table");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pvt_pkg.sv
hdl/pvt_entry_mem.sv
hdl/pvt_match_unit.sv
hdl/proximity_vote_table.sv
tb/sv/proximity_vote_table_check.sv
tb/sv/proximity_vote_table_test.sv
